// ===== hw/rtl/wsdc_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the waveform sample block.
// Used by wsdc_cfg, waveform_sample_to_dac_code_top and the testbench; depends on nothing else.
`default_nettype none

package wsdc_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;

    localparam int PHASE_UP   = (PHASE_BITS >= 32) ? (PHASE_BITS - 32) : 0;
    localparam int PHASE_DOWN = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;
    localparam int ALIGN_W    = 96;

    localparam int QTR_BITS = SINE_TABLE_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;
    localparam int QIDX_W   = QTR_BITS + 1;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_WAVE_SELECT   = 3'd0,
        REG_PHASE_STEP    = 3'd1,
        REG_PHASE_OFFSET  = 3'd2,
        REG_AMPLITUDE_MV  = 3'd3,
        REG_OFFSET_MV     = 3'd4,
        REG_PWM_THRESHOLD = 3'd5,
        REG_CODE_SCALE    = 3'd6,
        REG_MAX_CODE      = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        WAVE_PWM      = 2'd0,
        WAVE_SINE     = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef struct packed {
        wave_t              wave_select;
        logic [31:0]        phase_step;
        logic [31:0]        phase_offset;
        logic signed [15:0] amplitude_mv;
        logic signed [15:0] offset_mv;
        logic [32:0]        pwm_threshold;
        logic [31:0]        code_scale;
        logic [15:0]        max_code;
    } cfg_t;

    typedef logic [14:0] sine_rom_t [QTR_SIZE + 1];

    // sin(x) for x in [0, pi/2], x in Q2.30, result Q1.15 capped at 32767
    function automatic logic [14:0] sine_quarter(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        r  = (s + 64'd16384) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        for (int k = 0; k <= QTR_SIZE; k++)
        begin
            x      = (HALF_PI_Q30 * 64'(k)) >> QTR_BITS;
            rom[k] = sine_quarter(x);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Q0.32 register value to accumulator alignment
    function automatic logic [PHASE_BITS-1:0] align_in(logic [31:0] v);
        logic [ALIGN_W-1:0] w;
        w = ALIGN_W'(v);
        w = (w << PHASE_UP) >> PHASE_DOWN;
        return w[PHASE_BITS-1:0];
    endfunction

    // accumulator back to Q0.32
    function automatic logic [31:0] align_out(logic [PHASE_BITS-1:0] a);
        logic [ALIGN_W-1:0] w;
        w = ALIGN_W'(a);
        w = (w >> PHASE_UP) << PHASE_DOWN;
        return w[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsdc_cfg.sv =====
// Configuration register file with an APB-style port.
// Depends on wsdc_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module wsdc_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wsdc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [wsdc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [wsdc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output wsdc_pkg::cfg_t                           cfg
);

    wsdc_pkg::cfg_t     cfg_reg;
    wsdc_pkg::cfg_t     cfg_next;
    wsdc_pkg::reg_idx_t sel;
    logic               wr_en;

    assign sel    = wsdc_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                wsdc_pkg::REG_WAVE_SELECT:   cfg_next.wave_select   = wsdc_pkg::wave_t'(pwdata[1:0]);
                wsdc_pkg::REG_PHASE_STEP:    cfg_next.phase_step    = pwdata[31:0];
                wsdc_pkg::REG_PHASE_OFFSET:  cfg_next.phase_offset  = pwdata[31:0];
                wsdc_pkg::REG_AMPLITUDE_MV:  cfg_next.amplitude_mv  = pwdata[15:0];
                wsdc_pkg::REG_OFFSET_MV:     cfg_next.offset_mv     = pwdata[15:0];
                wsdc_pkg::REG_PWM_THRESHOLD: cfg_next.pwm_threshold = pwdata[32:0];
                wsdc_pkg::REG_CODE_SCALE:    cfg_next.code_scale    = pwdata[31:0];
                wsdc_pkg::REG_MAX_CODE:      cfg_next.max_code      = pwdata[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_select   <= wsdc_pkg::WAVE_SINE;
            cfg_reg.phase_step    <= 32'd4295;
            cfg_reg.phase_offset  <= 32'd0;
            cfg_reg.amplitude_mv  <= 16'sd1000;
            cfg_reg.offset_mv     <= 16'sd0;
            cfg_reg.pwm_threshold <= 33'h0_8000_0000;
            cfg_reg.code_scale    <= 32'd81920;
            cfg_reg.max_code      <= 16'd4095;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (sel)
            wsdc_pkg::REG_WAVE_SELECT:   prdata = 64'(cfg_reg.wave_select);
            wsdc_pkg::REG_PHASE_STEP:    prdata = 64'(cfg_reg.phase_step);
            wsdc_pkg::REG_PHASE_OFFSET:  prdata = 64'(cfg_reg.phase_offset);
            wsdc_pkg::REG_AMPLITUDE_MV:  prdata = 64'(unsigned'(cfg_reg.amplitude_mv));
            wsdc_pkg::REG_OFFSET_MV:     prdata = 64'(unsigned'(cfg_reg.offset_mv));
            wsdc_pkg::REG_PWM_THRESHOLD: prdata = 64'(cfg_reg.pwm_threshold);
            wsdc_pkg::REG_CODE_SCALE:    prdata = 64'(cfg_reg.code_scale);
            wsdc_pkg::REG_MAX_CODE:      prdata = 64'(cfg_reg.max_code);
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/waveform_sample_to_dac_code_top.sv =====
// Waveform sample to DAC code: seven-stage pipeline from time stamp to DAC code.
// Depends on wsdc_pkg and wsdc_cfg.
//
// One time stamp is taken per clock unless an output stall has backed up to the
// first stage, and each passes through the stages in order (phase multiply-add,
// waveform select, sine table, amplitude multiply, rounding and saturation, code
// scale multiply, clipping), with one of the seven pipeline registers per stage.
// A stall on the output holds only the stages that are full, so empty stages keep
// filling. Write the registers only while no transfer is in flight.
`default_nettype none

module waveform_sample_to_dac_code_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // time_us[63:0]
    input  wire logic [wsdc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // sample_mv[16:0], dac_code[32:17], clip_high[33], clip_low[34], zero[39:35]
    output logic      [wsdc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wsdc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [wsdc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [wsdc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int PB     = wsdc_pkg::PHASE_BITS;
    localparam int STB    = wsdc_pkg::SINE_TABLE_BITS;
    localparam int QB     = wsdc_pkg::QTR_BITS;
    localparam int QW     = wsdc_pkg::QIDX_W;
    localparam int NSTAGE = 7;

    wsdc_pkg::cfg_t cfg;

    wsdc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = ~vld_reg[NSTAGE-1] | m_axis_tready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = ~vld_reg[i] | en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NSTAGE-1];

    // stage 1: phase accumulator
    logic [PB-1:0] mul_full;
    logic [PB-1:0] acc_reg;
    logic [PB-1:0] acc_next;

    assign mul_full = PB'(s_axis_tdata[PB-1:0] * wsdc_pkg::align_in(cfg.phase_step));
    assign acc_next = mul_full + wsdc_pkg::align_in(cfg.phase_offset);

    // stage 2: waveform from phase, sine index
    logic [31:0]        phase;
    logic [14:0]        p15;
    logic [STB-1:0]     sidx;
    logic [QB-1:0]      sq;
    logic signed [16:0] wpre_reg;
    logic signed [16:0] wpre_next;
    logic [QW-1:0]      k_reg;
    logic [QW-1:0]      k_next;
    logic               neg_reg;
    logic               neg_next;
    logic               sine_reg;
    logic               sine_next;

    assign phase = wsdc_pkg::align_out(acc_reg);
    assign p15   = phase[31:17];
    assign sidx  = phase[31 -: STB];
    assign sq    = sidx[QB-1:0];

    always_comb
    begin
        k_next    = sidx[QB] ? (QW'(wsdc_pkg::QTR_SIZE) - QW'(sq)) : QW'(sq);
        neg_next  = sidx[STB-1];
        sine_next = (cfg.wave_select == wsdc_pkg::WAVE_SINE);
        case (cfg.wave_select)
            wsdc_pkg::WAVE_PWM:
                wpre_next = ({1'b0, phase} < cfg.pwm_threshold) ? 17'sd32768 : 17'sd0;
            wsdc_pkg::WAVE_SAW:
                wpre_next = signed'(17'(p15));
            wsdc_pkg::WAVE_TRIANGLE:
                wpre_next = phase[31] ? signed'(17'd65536 - {1'b0, p15, 1'b0})
                                      : signed'({1'b0, p15, 1'b0});
            default:
                wpre_next = 17'sd0;
        endcase
    end

    // stage 3: sine table
    logic [14:0]        rom_q;
    logic signed [16:0] wave_reg;
    logic signed [16:0] wave_next;

    assign rom_q = wsdc_pkg::SINE_ROM[k_reg];

    always_comb
    begin
        if (sine_reg)
        begin
            wave_next = neg_reg ? -signed'(17'(rom_q)) : signed'(17'(rom_q));
        end
        else
        begin
            wave_next = wpre_reg;
        end
    end

    // stage 4: amplitude and offset
    logic signed [33:0] sum_reg;
    logic signed [33:0] sum_next;

    assign sum_next = 34'(cfg.amplitude_mv * wave_reg) + (34'(cfg.offset_mv) <<< 15);

    // stage 5: round and saturate
    logic signed [33:0] rnd;
    logic signed [18:0] mv_wide;
    logic signed [16:0] mv_reg;
    logic signed [16:0] mv_next;

    assign rnd     = sum_reg + 34'sd16384;
    assign mv_wide = 19'(rnd >>> 15);

    always_comb
    begin
        if (mv_wide > 19'sd65535)
        begin
            mv_next = 17'sd65535;
        end
        else if (mv_wide < -19'sd65536)
        begin
            mv_next = -17'sd65536;
        end
        else
        begin
            mv_next = mv_wide[16:0];
        end
    end

    // stage 6: scale to codes
    logic signed [49:0] prod_reg;
    logic signed [49:0] prod_next;
    logic signed [16:0] mv6_reg;
    logic signed [16:0] mv6_next;

    assign prod_next = mv_reg * signed'({1'b0, cfg.code_scale});
    assign mv6_next  = mv_reg;

    // stage 7: clip
    logic signed [49:0] lim;
    logic signed [16:0] omv_reg;
    logic signed [16:0] omv_next;
    logic [15:0]        code_reg;
    logic [15:0]        code_next;
    logic               hi_reg;
    logic               hi_next;
    logic               lo_reg;
    logic               lo_next;

    assign lim      = signed'(50'({cfg.max_code, 16'd0}));
    assign omv_next = mv6_reg;

    always_comb
    begin
        hi_next   = 1'b0;
        lo_next   = 1'b0;
        code_next = prod_reg[31:16];
        if (prod_reg > lim)
        begin
            hi_next   = 1'b1;
            code_next = (cfg.max_code == 16'd0) ? 16'd0 : (cfg.max_code - 16'd1);
        end
        else if (prod_reg < 50'sd0)
        begin
            lo_next   = 1'b1;
            code_next = 16'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            acc_reg <= acc_next;
        end
        if (en[1])
        begin
            wpre_reg <= wpre_next;
            k_reg    <= k_next;
            neg_reg  <= neg_next;
            sine_reg <= sine_next;
        end
        if (en[2])
        begin
            wave_reg <= wave_next;
        end
        if (en[3])
        begin
            sum_reg <= sum_next;
        end
        if (en[4])
        begin
            mv_reg <= mv_next;
        end
        if (en[5])
        begin
            prod_reg <= prod_next;
            mv6_reg  <= mv6_next;
        end
        if (en[6])
        begin
            omv_reg  <= omv_next;
            code_reg <= code_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
        end
    end

    assign m_axis_tdata = {5'd0, lo_reg, hi_reg, code_reg, unsigned'(omv_reg)};

endmodule

`default_nettype wire

// ===== sim/tb_waveform_sample_to_dac_code_top.sv =====
// Testbench for waveform_sample_to_dac_code_top: time stamps in, DAC samples out.
// Predicts every sample from a local copy of the registers; depends on wsdc_pkg and waveform_sample_to_dac_code_top.
`timescale 1ns / 1ps

module tb_waveform_sample_to_dac_code_top;

    typedef struct packed {
        logic signed [16:0] sample_mv;
        logic [15:0]        dac_code;
        logic               clip_high;
        logic               clip_low;
    } dac_sample_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [wsdc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [wsdc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [wsdc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [wsdc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [wsdc_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    wsdc_pkg::cfg_t shadow_cfg;
    dac_sample_t    pending_samples[$];
    int             error_count;
    int             gap_max;
    int             stall_max;
    int             hold_off_cycles;

    waveform_sample_to_dac_code_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 40)
        begin
            $display("mismatch %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
        end
    endtask

    // quarter-wave symmetric sine, Q1.15, from a Q2.30 Taylor series
    function automatic longint sine_sample(int unsigned idx);
        longint unsigned taylor_div[5] = '{110, 72, 42, 20, 6};
        int unsigned     quad;
        int unsigned     q;
        int unsigned     k;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        quad = (idx >> wsdc_pkg::QTR_BITS) & 3;
        q    = idx & (wsdc_pkg::QTR_SIZE - 1);
        k    = quad[0] ? (wsdc_pkg::QTR_SIZE - q) : q;
        x    = (wsdc_pkg::HALF_PI_Q30 * longint'(k)) >> wsdc_pkg::QTR_BITS;
        x2   = (x * x) >> 30;
        t    = wsdc_pkg::Q30_ONE;
        for (int i = 0; i < 5; i++)
        begin
            t = wsdc_pkg::Q30_ONE - (((x2 * t) >> 30) / taylor_div[i]);
        end
        s = (x * t) >> 30;
        r = (s + 16384) >> 15;
        if (r > 32767)
        begin
            r = 32767;
        end
        return (quad >= 2) ? -longint'(r) : longint'(r);
    endfunction

    function automatic dac_sample_t predict_dac_sample(logic [63:0] time_us);
        logic [127:0] step_al;
        logic [127:0] off_al;
        logic [127:0] acc;
        logic [31:0]  phase;
        longint       p15;
        longint       wave;
        longint       sum;
        longint       mv;
        longint       prod;
        longint       lim;
        dac_sample_t  res;
        step_al = (128'(shadow_cfg.phase_step) << wsdc_pkg::PHASE_UP) >> wsdc_pkg::PHASE_DOWN;
        off_al  = (128'(shadow_cfg.phase_offset) << wsdc_pkg::PHASE_UP) >> wsdc_pkg::PHASE_DOWN;
        acc     = (128'(time_us) * step_al + off_al)
                & ((128'd1 << wsdc_pkg::PHASE_BITS) - 1);
        phase   = 32'((acc >> wsdc_pkg::PHASE_UP) << wsdc_pkg::PHASE_DOWN);
        p15     = longint'(phase >> 17);
        case (shadow_cfg.wave_select)
            wsdc_pkg::WAVE_PWM:
                wave = ({1'b0, phase} < shadow_cfg.pwm_threshold) ? 32768 : 0;
            wsdc_pkg::WAVE_SINE:
                wave = sine_sample(phase >> (32 - wsdc_pkg::SINE_TABLE_BITS));
            wsdc_pkg::WAVE_SAW:
                wave = p15;
            default:
                wave = phase[31] ? (65536 - 2 * p15) : (2 * p15);
        endcase
        sum = longint'(shadow_cfg.amplitude_mv) * wave
            + longint'(shadow_cfg.offset_mv) * 32768;
        mv  = (sum + 16384) >>> 15;
        if (mv > 65535)
        begin
            mv = 65535;
        end
        if (mv < -65536)
        begin
            mv = -65536;
        end
        prod          = mv * longint'(shadow_cfg.code_scale);
        lim           = longint'(shadow_cfg.max_code) * 65536;
        res.sample_mv = 17'(mv);
        res.clip_high = 1'b0;
        res.clip_low  = 1'b0;
        if (prod > lim)
        begin
            res.dac_code  = (shadow_cfg.max_code == 16'd0) ? 16'd0 : shadow_cfg.max_code - 16'd1;
            res.clip_high = 1'b1;
        end
        else if (prod < 0)
        begin
            res.dac_code = 16'd0;
            res.clip_low = 1'b1;
        end
        else
        begin
            res.dac_code = 16'(prod >>> 16);
        end
        return res;
    endfunction

    function automatic logic [63:0] reg_mask(wsdc_pkg::reg_idx_t idx);
        case (idx)
            wsdc_pkg::REG_WAVE_SELECT:   return 64'h3;
            wsdc_pkg::REG_PWM_THRESHOLD: return 64'h1_FFFF_FFFF;
            wsdc_pkg::REG_AMPLITUDE_MV,
            wsdc_pkg::REG_OFFSET_MV,
            wsdc_pkg::REG_MAX_CODE:      return 64'hFFFF;
            default:                     return 64'hFFFF_FFFF;
        endcase
    endfunction

    task automatic apb_transfer(input logic wr, input wsdc_pkg::reg_idx_t idx,
                                input logic [63:0] wdata, output logic [63:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 3'b000};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic cfg_write(input wsdc_pkg::reg_idx_t idx, input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] rd;
        v = value & reg_mask(idx);
        apb_transfer(1'b1, idx, v, rd);
        case (idx)
            wsdc_pkg::REG_WAVE_SELECT:   shadow_cfg.wave_select   = wsdc_pkg::wave_t'(v[1:0]);
            wsdc_pkg::REG_PHASE_STEP:    shadow_cfg.phase_step    = v[31:0];
            wsdc_pkg::REG_PHASE_OFFSET:  shadow_cfg.phase_offset  = v[31:0];
            wsdc_pkg::REG_AMPLITUDE_MV:  shadow_cfg.amplitude_mv  = v[15:0];
            wsdc_pkg::REG_OFFSET_MV:     shadow_cfg.offset_mv     = v[15:0];
            wsdc_pkg::REG_PWM_THRESHOLD: shadow_cfg.pwm_threshold = v[32:0];
            wsdc_pkg::REG_CODE_SCALE:    shadow_cfg.code_scale    = v[31:0];
            default:                     shadow_cfg.max_code      = v[15:0];
        endcase
        apb_transfer(1'b0, idx, 64'd0, rd);
        if ((rd & reg_mask(idx)) !== v)
        begin
            report_mismatch(idx.name(), rd & reg_mask(idx), v);
        end
    endtask

    function automatic logic [63:0] random_reg_value(wsdc_pkg::reg_idx_t idx);
        int pick;
        pick = $urandom_range(0, 5);
        case (idx)
            wsdc_pkg::REG_WAVE_SELECT:
                return $urandom_range(0, 3);
            wsdc_pkg::REG_PWM_THRESHOLD:
                return (pick == 0) ? 64'h1_0000_0000 : (pick == 1) ? 64'd0 : 64'($urandom);
            wsdc_pkg::REG_AMPLITUDE_MV,
            wsdc_pkg::REG_OFFSET_MV:
                return (pick == 0) ? 64'h8000 : (pick == 1) ? 64'h7FFF : $urandom_range(0, 65535);
            wsdc_pkg::REG_MAX_CODE:
                return (pick == 0) ? 64'd1 : (pick == 1) ? 64'd65535 : $urandom_range(1, 65535);
            wsdc_pkg::REG_CODE_SCALE:
                return (pick == 0) ? 64'd0 : (pick == 1) ? 64'hFFFF_FFFF :
                       (pick < 4) ? $urandom_range(0, 200000) : 64'($urandom);
            default:
                return (pick == 0) ? 64'd0 : (pick == 1) ? 64'hFFFF_FFFF : 64'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] random_time();
        case ($urandom_range(0, 3))
            0, 1:    return {$urandom, $urandom};
            2:       return $urandom_range(0, 100000);
            default: return {32'hFFFF_FFFF, $urandom};
        endcase
    endfunction

    task automatic send_time(input logic [63:0] time_us);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = time_us;
        do @(posedge clk); while (!s_axis_tready);
        pending_samples.push_back(predict_dac_sample(time_us));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_samples.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // sample and check each output transfer
    initial
    begin
        dac_sample_t got;
        dac_sample_t want;
        int          stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
            if (hold_off_cycles > 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = dac_sample_t'({m_axis_tdata[16:0], m_axis_tdata[32:17],
                                 m_axis_tdata[33], m_axis_tdata[34]});
            if (pending_samples.size() == 0)
            begin
                report_mismatch("unexpected sample", 64'(m_axis_tdata), 64'd0);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (got.sample_mv !== want.sample_mv)
                begin
                    report_mismatch("sample_mv", 64'(got.sample_mv), 64'(want.sample_mv));
                end
                if (got.dac_code !== want.dac_code)
                begin
                    report_mismatch("dac_code", 64'(got.dac_code), 64'(want.dac_code));
                end
                if (got.clip_high !== want.clip_high)
                begin
                    report_mismatch("clip_high", 64'(got.clip_high), 64'(want.clip_high));
                end
                if (got.clip_low !== want.clip_low)
                begin
                    report_mismatch("clip_low", 64'(got.clip_low), 64'(want.clip_low));
                end
            end
            @(negedge clk);
        end
    end

    task automatic test_reset_defaults();
        gap_max   = 14;
        stall_max = 14;
        repeat (20) send_time(random_time());
        wait_for_results();
    endtask

    task automatic test_directed_edges();
        gap_max   = 3;
        stall_max = 3;
        cfg_write(wsdc_pkg::REG_WAVE_SELECT, wsdc_pkg::WAVE_PWM);
        cfg_write(wsdc_pkg::REG_PHASE_STEP, 64'd1);
        cfg_write(wsdc_pkg::REG_PHASE_OFFSET, 64'd0);
        cfg_write(wsdc_pkg::REG_AMPLITUDE_MV, 64'd1000);
        cfg_write(wsdc_pkg::REG_OFFSET_MV, 64'd0);
        cfg_write(wsdc_pkg::REG_PWM_THRESHOLD, 64'h8000_0000);
        cfg_write(wsdc_pkg::REG_CODE_SCALE, 64'd81920);
        cfg_write(wsdc_pkg::REG_MAX_CODE, 64'd4095);
        send_time(64'd0);
        send_time(64'h8000_0000);
        send_time(64'h7FFF_FFFF);
        wait_for_results();
        cfg_write(wsdc_pkg::REG_PWM_THRESHOLD, 64'h1_0000_0000);
        send_time(64'hFFFF_FFFF);
        wait_for_results();
        cfg_write(wsdc_pkg::REG_PWM_THRESHOLD, 64'd0);
        send_time(64'd0);
        wait_for_results();

        cfg_write(wsdc_pkg::REG_WAVE_SELECT, wsdc_pkg::WAVE_SINE);
        cfg_write(wsdc_pkg::REG_PHASE_STEP, 64'h0040_0000);
        cfg_write(wsdc_pkg::REG_AMPLITUDE_MV, 64'h7FFF);
        cfg_write(wsdc_pkg::REG_OFFSET_MV, 64'h7FFF);
        cfg_write(wsdc_pkg::REG_CODE_SCALE, 64'h1_0000);
        cfg_write(wsdc_pkg::REG_MAX_CODE, 64'hFFFF);
        send_time(64'd0);
        send_time(64'd256);
        send_time(64'd512);
        send_time(64'd768);
        send_time(64'd1023);
        wait_for_results();
        cfg_write(wsdc_pkg::REG_AMPLITUDE_MV, 64'h8000);
        cfg_write(wsdc_pkg::REG_OFFSET_MV, 64'h8000);
        send_time(64'd256);
        send_time(64'd768);
        wait_for_results();

        cfg_write(wsdc_pkg::REG_WAVE_SELECT, wsdc_pkg::WAVE_SAW);
        cfg_write(wsdc_pkg::REG_PHASE_STEP, 64'hFFFF_FFFF);
        cfg_write(wsdc_pkg::REG_PHASE_OFFSET, 64'hFFFF_FFFF);
        cfg_write(wsdc_pkg::REG_AMPLITUDE_MV, 64'h7FFF);
        cfg_write(wsdc_pkg::REG_OFFSET_MV, 64'd0);
        cfg_write(wsdc_pkg::REG_CODE_SCALE, 64'hFFFF_FFFF);
        cfg_write(wsdc_pkg::REG_MAX_CODE, 64'd1);
        send_time(64'd0);
        send_time(64'hFFFF_FFFF_FFFF_FFFF);
        send_time(64'h8000_0000_0000_0000);
        wait_for_results();
        cfg_write(wsdc_pkg::REG_CODE_SCALE, 64'd0);
        send_time(64'd0);
        wait_for_results();

        cfg_write(wsdc_pkg::REG_WAVE_SELECT, wsdc_pkg::WAVE_TRIANGLE);
        cfg_write(wsdc_pkg::REG_PHASE_STEP, 64'd1);
        cfg_write(wsdc_pkg::REG_PHASE_OFFSET, 64'd0);
        cfg_write(wsdc_pkg::REG_AMPLITUDE_MV, 64'd1000);
        cfg_write(wsdc_pkg::REG_OFFSET_MV, 64'hFE0C);
        cfg_write(wsdc_pkg::REG_CODE_SCALE, 64'd81920);
        cfg_write(wsdc_pkg::REG_MAX_CODE, 64'd4095);
        send_time(64'd0);
        send_time(64'h4000_0000);
        send_time(64'h8000_0000);
        send_time(64'hC000_0000);
        wait_for_results();
    endtask

    task automatic test_random_settings();
        for (int phase_no = 0; phase_no < 12; phase_no++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cfg_write(wsdc_pkg::reg_idx_t'(i), random_reg_value(wsdc_pkg::reg_idx_t'(i)));
            end
            gap_max   = (phase_no % 3 == 0) ? 0 : 14;
            stall_max = (phase_no % 4 == 1) ? 0 : 14;
            repeat (70) send_time(random_time());
            wait_for_results();
        end
    endtask

    task automatic test_output_backpressure();
        cfg_write(wsdc_pkg::REG_WAVE_SELECT, wsdc_pkg::WAVE_SAW);
        cfg_write(wsdc_pkg::REG_PHASE_STEP, 64'h0123_4567);
        gap_max         = 0;
        stall_max       = 2;
        hold_off_cycles = 120;
        repeat (48) send_time(random_time());
        wait_for_results();
    endtask

    task automatic test_sender_pause();
        cfg_write(wsdc_pkg::REG_WAVE_SELECT, wsdc_pkg::WAVE_SINE);
        gap_max   = 14;
        stall_max = 14;
        repeat (15) send_time(random_time());
        wait_for_results();
        gap_max   = 0;
        stall_max = 0;
        repeat (15) send_time(random_time());
        wait_for_results();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        error_count     = 0;
        gap_max         = 0;
        stall_max       = 0;
        hold_off_cycles = 0;
        shadow_cfg      = '{wave_select: wsdc_pkg::WAVE_SINE, phase_step: 32'd4295,
                            phase_offset: 32'd0,
                            amplitude_mv: 16'sd1000, offset_mv: 16'sd0,
                            pwm_threshold: 33'h0_8000_0000, code_scale: 32'd81920,
                            max_code: 16'd4095};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_edges();
        test_random_settings();
        test_output_backpressure();
        test_sender_pause();

        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
